// ===== design/knc_pkg.sv =====
// knc_pkg: shared widths, request and register codes, state codes and the
// distance/id ordering function for the k-nearest candidate selector
// no dependencies
package knc_pkg;

    localparam int DIST_W    = 31;
    localparam int KW_W      = 5;
    localparam int REQ_W     = 2;
    localparam int ENTRY_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ID_MAX_W  = 32;

    localparam logic [DIST_W-1:0] INIT_BOUND_RST = 31'd2139095040;
    localparam logic [KW_W-1:0]   K_WANTED_RST   = 5'd5;

    typedef enum logic [REQ_W-1:0] {
        REQ_OFFER = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K_WANTED   = 2'd0,
        CFG_INIT_BOUND = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LAUNCH = 3'b010,
        ST_SCAN   = 3'b100
    } state_t;

    // control bits of the scan token walking the cell row
    typedef struct packed {
        logic valid;
        logic have;
    } tok_ctl_t;

    // entry a is farther than entry b: larger distance, ties go to the higher id
    function automatic logic farther(input logic [DIST_W-1:0]   dist_a,
                                     input logic [ID_MAX_W-1:0] id_a,
                                     input logic [DIST_W-1:0]   dist_b,
                                     input logic [ID_MAX_W-1:0] id_b);
        logic res;
        if (dist_a != dist_b)
        begin
            res = dist_a > dist_b;
        end
        else
        begin
            res = id_a > id_b;
        end
        return res;
    endfunction

endpackage

// ===== design/knc_if.sv =====
// knc_if: valid/ready channel interfaces of the selector (config, request, result)
// depends on knc_pkg
interface knc_cfg_if
    import knc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIST_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface knc_req_if
    import knc_pkg::*;
#(
    parameter int ID_WIDTH = 16
);
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_WIDTH-1:0] cand_id;
    logic [DIST_W-1:0]   cand_dist_sq;
    logic [ENTRY_W-1:0]  entry_index;

    modport source (output valid, output req_type, output cand_id, output cand_dist_sq,
                    output entry_index, input ready);
    modport sink   (input valid, input req_type, input cand_id, input cand_dist_sq,
                    input entry_index, output ready);
endinterface

interface knc_res_if
    import knc_pkg::*;
#(
    parameter int ID_WIDTH  = 16,
    parameter int CNT_WIDTH = 5
);
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 evicted;
    logic [ID_WIDTH-1:0]  evicted_id;
    logic [CNT_WIDTH-1:0] found_count;
    logic [DIST_W-1:0]    bound_sq;
    logic [DIST_W-1:0]    farthest_sq;
    logic                 read_valid;
    logic [ID_WIDTH-1:0]  read_id;
    logic [DIST_W-1:0]    read_dist_sq;

    modport source (output valid, output accepted, output evicted, output evicted_id,
                    output found_count, output bound_sq, output farthest_sq,
                    output read_valid, output read_id, output read_dist_sq, input ready);
    modport sink   (input valid, input accepted, input evicted, input evicted_id,
                    input found_count, input bound_sq, input farthest_sq,
                    input read_valid, input read_id, input read_dist_sq, output ready);
endinterface

// ===== design/knc_cell.sv =====
// knc_cell: one stored slot plus one stage of the farthest-entry scan row
// depends on knc_pkg
module knc_cell
    import knc_pkg::*;
#(
    parameter int ID_WIDTH   = 16,
    parameter int IDX_WIDTH  = 4,
    parameter int CELL_INDEX = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [DIST_W-1:0]    wr_dist,
    input  logic [ID_WIDTH-1:0]  wr_id,
    input  logic                 live,
    input  tok_ctl_t             tok_in_ctl,
    input  logic [DIST_W-1:0]    tok_in_dist,
    input  logic [ID_WIDTH-1:0]  tok_in_id,
    input  logic [IDX_WIDTH-1:0] tok_in_idx,
    output tok_ctl_t             tok_out_ctl,
    output logic [DIST_W-1:0]    tok_out_dist,
    output logic [ID_WIDTH-1:0]  tok_out_id,
    output logic [IDX_WIDTH-1:0] tok_out_idx,
    output logic [DIST_W-1:0]    slot_dist,
    output logic [ID_WIDTH-1:0]  slot_id
);

    logic [DIST_W-1:0]    slot_dist_reg;
    logic [ID_WIDTH-1:0]  slot_id_reg;
    tok_ctl_t             tok_ctl_reg;
    logic [DIST_W-1:0]    tok_dist_reg;
    logic [ID_WIDTH-1:0]  tok_id_reg;
    logic [IDX_WIDTH-1:0] tok_idx_reg;
    logic                 take_own;

    // this slot beats the token if it is stored and farther than the best so far
    assign take_own = live && (!tok_in_ctl.have ||
                      farther(slot_dist_reg, ID_MAX_W'(slot_id_reg),
                              tok_in_dist, ID_MAX_W'(tok_in_id)));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_dist_reg <= wr_dist;
            slot_id_reg   <= wr_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_ctl_reg <= '0;
        end
        else
        begin
            tok_ctl_reg.valid <= tok_in_ctl.valid;
            tok_ctl_reg.have  <= tok_in_ctl.have || take_own;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_own)
        begin
            tok_dist_reg <= slot_dist_reg;
            tok_id_reg   <= slot_id_reg;
            tok_idx_reg  <= IDX_WIDTH'(CELL_INDEX);
        end
        else
        begin
            tok_dist_reg <= tok_in_dist;
            tok_id_reg   <= tok_in_id;
            tok_idx_reg  <= tok_in_idx;
        end
    end

    assign tok_out_ctl  = tok_ctl_reg;
    assign tok_out_dist = tok_dist_reg;
    assign tok_out_id   = tok_id_reg;
    assign tok_out_idx  = tok_idx_reg;
    assign slot_dist    = slot_dist_reg;
    assign slot_id      = slot_id_reg;

endmodule

// ===== design/k_nearest_candidate_selector_top.sv =====
// k_nearest_candidate_selector_top: keeps the k closest candidates of a query
// depends on knc_pkg, knc_if (channel interfaces) and knc_cell
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-------------------------------------------------
//   cfg     | in  | valid/ready      | index (0 k_wanted, 1 initial_bound_sq), data
//   req     | in  | valid/ready      | req_type, cand_id, cand_dist_sq, entry_index
//   res     | out | valid/ready      | accepted, evicted, evicted_id, found_count,
//           |     |                  | bound_sq, farthest_sq, read_valid, read_id,
//           |     |                  | read_dist_sq
//
// one item per cycle while req.ready is high for clear, read, rejected offers and
// appends: the result is registered at the accepting edge, into the output
// register or, if that is held, into the skid; an offer that evicts overwrites the
// farthest slot, then passes ST_LAUNCH and ST_SCAN while a scan token walks the row
// of K_MAX cells, one cell per cycle, to find the new farthest entry and bound
// reset clears the count, sets the bound to the reset value of initial_bound_sq;
// slot contents are undefined until written
// results go through an output register and a one-item skid; req.ready drops
// while the skid holds an item or while a scan runs; cfg is always ready
module k_nearest_candidate_selector_top
    import knc_pkg::*;
#(
    parameter int K_MAX    = 16,
    parameter int ID_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    knc_cfg_if.sink    cfg,
    knc_req_if.sink    req,
    knc_res_if.source  res
);

    localparam int CW    = $clog2(K_MAX + 1);
    localparam int IW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int RES_W = 2 + ID_WIDTH + CW + 3 * DIST_W + 1 + ID_WIDTH;

    // configuration registers
    logic [KW_W-1:0]   k_wanted_reg;
    logic [DIST_W-1:0] init_bound_reg;

    // query state
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DIST_W-1:0] bound_reg, bound_next;
    logic [DIST_W-1:0] far_dist_reg, far_dist_next;
    logic [ID_WIDTH-1:0] far_id_reg, far_id_next;
    logic [IW-1:0]     far_idx_reg, far_idx_next;
    logic [ID_WIDTH-1:0] evid_reg, evid_next;

    // output register and skid
    logic              out_valid_reg;
    logic [RES_W-1:0]  out_reg;
    logic              skid_valid_reg;
    logic [RES_W-1:0]  skid_reg;

    logic              req_fire;
    logic              pop;
    logic [CW-1:0]     k_eff;
    req_kind_t         req_kind;

    // cell row wiring, entry 0 is the token injected by the sequencer
    tok_ctl_t            tok_ctl  [K_MAX+1];
    logic [DIST_W-1:0]   tok_dist [K_MAX+1];
    logic [ID_WIDTH-1:0] tok_id   [K_MAX+1];
    logic [IW-1:0]       tok_idx  [K_MAX+1];
    logic [DIST_W-1:0]   cell_dist [K_MAX];
    logic [ID_WIDTH-1:0] cell_id   [K_MAX];
    logic [K_MAX-1:0]    live;
    logic [K_MAX-1:0]    wr_en;

    // result being produced this cycle
    logic              push;
    logic              push_acc;
    logic              push_ev;
    logic              rd_valid;
    logic [ID_WIDTH-1:0] rd_id;
    logic [DIST_W-1:0] rd_dist;
    logic [RES_W-1:0]  push_data;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign pop       = out_valid_reg && res.ready;
    assign req_kind  = req_kind_t'(req.req_type);
    assign cfg.ready = 1'b1;

    // k_wanted of zero acts as one, values above the row length are clipped
    always_comb
    begin
        if (k_wanted_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (32'(k_wanted_reg) > K_MAX)
        begin
            k_eff = CW'(K_MAX);
        end
        else
        begin
            k_eff = CW'(k_wanted_reg);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_wanted_reg   <= K_WANTED_RST;
            init_bound_reg <= INIT_BOUND_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_K_WANTED:   k_wanted_reg   <= cfg.data[KW_W-1:0];
                CFG_INIT_BOUND: init_bound_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // the row of cells: slot storage plus the farthest-entry scan
    assign tok_ctl[0].valid = (state_reg == ST_LAUNCH);
    assign tok_ctl[0].have  = 1'b0;
    assign tok_dist[0]      = '0;
    assign tok_id[0]        = '0;
    assign tok_idx[0]       = '0;

    for (genvar i = 0; i < K_MAX; i++)
    begin : g_cell
        assign live[i] = CW'(i) < count_reg;

        knc_cell #(
            .ID_WIDTH   (ID_WIDTH),
            .IDX_WIDTH  (IW),
            .CELL_INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .wr_en        (wr_en[i]),
            .wr_dist      (req.cand_dist_sq),
            .wr_id        (req.cand_id),
            .live         (live[i]),
            .tok_in_ctl   (tok_ctl[i]),
            .tok_in_dist  (tok_dist[i]),
            .tok_in_id    (tok_id[i]),
            .tok_in_idx   (tok_idx[i]),
            .tok_out_ctl  (tok_ctl[i+1]),
            .tok_out_dist (tok_dist[i+1]),
            .tok_out_id   (tok_id[i+1]),
            .tok_out_idx  (tok_idx[i+1]),
            .slot_dist    (cell_dist[i]),
            .slot_id      (cell_id[i])
        );
    end

    // read port: only stored slots answer, anything else reads as zero
    always_comb
    begin
        rd_valid = 1'b0;
        rd_id    = '0;
        rd_dist  = '0;
        for (int i = 0; i < K_MAX; i++)
        begin
            if (live[i] && (32'(req.entry_index) == i))
            begin
                rd_valid = 1'b1;
                rd_id    = cell_id[i];
                rd_dist  = cell_dist[i];
            end
        end
    end

    // sequencer: decides each item, starts a scan after an eviction
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        bound_next    = bound_reg;
        far_dist_next = far_dist_reg;
        far_id_next   = far_id_reg;
        far_idx_next  = far_idx_reg;
        evid_next     = evid_reg;
        wr_en         = '0;
        push          = 1'b0;
        push_acc      = 1'b0;
        push_ev       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_kind)
                        REQ_OFFER:
                        begin
                            if (req.cand_dist_sq < bound_reg)
                            begin
                                if (count_reg < k_eff)
                                begin
                                    // append at the end, farthest tracked incrementally
                                    wr_en[count_reg[IW-1:0]] = 1'b1;
                                    count_next = CW'(count_reg + 1'b1);
                                    if ((count_reg == '0) ||
                                        farther(req.cand_dist_sq, ID_MAX_W'(req.cand_id),
                                                far_dist_reg, ID_MAX_W'(far_id_reg)))
                                    begin
                                        far_dist_next = req.cand_dist_sq;
                                        far_id_next   = req.cand_id;
                                        far_idx_next  = count_reg[IW-1:0];
                                    end
                                    if (count_next == k_eff)
                                    begin
                                        bound_next = far_dist_next;
                                    end
                                    push     = 1'b1;
                                    push_acc = 1'b1;
                                end
                                else
                                begin
                                    // store full: overwrite the farthest slot, then rescan
                                    wr_en[far_idx_reg] = 1'b1;
                                    evid_next  = far_id_reg;
                                    state_next = ST_LAUNCH;
                                end
                            end
                            else
                            begin
                                push = 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next    = '0;
                            bound_next    = init_bound_reg;
                            far_dist_next = '0;
                            push          = 1'b1;
                        end
                        REQ_READ:
                        begin
                            push = 1'b1;
                        end
                        REQ_NONE:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // token leaving the last cell carries the new farthest entry
                if (tok_ctl[K_MAX].valid)
                begin
                    far_dist_next = tok_dist[K_MAX];
                    far_id_next   = tok_id[K_MAX];
                    far_idx_next  = tok_idx[K_MAX];
                    bound_next    = tok_dist[K_MAX];
                    push          = 1'b1;
                    push_acc      = 1'b1;
                    push_ev       = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read fields only mean something on a read item taken in this cycle
    assign push_data = {push_acc,
                        push_ev,
                        push_ev ? evid_reg : {ID_WIDTH{1'b0}},
                        count_next,
                        bound_next,
                        far_dist_next,
                        (req_fire && req_kind == REQ_READ) ? rd_valid : 1'b0,
                        (req_fire && req_kind == REQ_READ) ? rd_id : {ID_WIDTH{1'b0}},
                        (req_fire && req_kind == REQ_READ) ? rd_dist : {DIST_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            bound_reg    <= INIT_BOUND_RST;
            far_dist_reg <= '0;
            far_id_reg   <= '0;
            far_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            bound_reg    <= bound_next;
            far_dist_reg <= far_dist_next;
            far_id_reg   <= far_id_next;
            far_idx_reg  <= far_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evid_reg <= evid_next;
    end

    // output register with a one-item skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                out_reg <= push_data;
            end
        end
    end

    assign res.valid = out_valid_reg;
    assign {res.accepted,
            res.evicted,
            res.evicted_id,
            res.found_count,
            res.bound_sq,
            res.farthest_sq,
            res.read_valid,
            res.read_id,
            res.read_dist_sq} = out_reg;

endmodule
